@@ rtl/core/vdib_pkg.sv @@
// types, constants and the ordering key for the vector dedup index builder
// depends on nothing; the builder, the checker and the testbench import it
package vdib_pkg;

  typedef struct packed {
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic        final_item;
  } item_t;

  typedef struct packed {
    logic [5:0]  rank_index;
    logic        uniq_valid;
    logic [31:0] uniq_x;
    logic [31:0] uniq_y;
    logic [31:0] uniq_z;
    logic [6:0]  uniq_total;
    logic        overflow;
    logic        end_of_run;
  } result_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_HOLD,
    S_SCAN,
    S_COMMIT,
    S_ORD,
    S_OLOAD
  } state_t;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

  // map a float bit pattern onto an unsigned key that sorts numerically
  function automatic logic [31:0] order_key(input logic [31:0] bits);
    logic [31:0] b;
    b = (bits == SIGN_BIT) ? 32'h0 : bits;
    return b[31] ? ~b : (b | SIGN_BIT);
  endfunction

  // x, then y, then z
  function automatic logic [95:0] vec_key(input logic [95:0] v);
    return {order_key(v[95:64]), order_key(v[63:32]), order_key(v[31:0])};
  endfunction

endpackage

@@ rtl/core/vector_dedup_index_builder.sv @@
// vector dedup index builder: load a list, then sort, dedup and remap it
// loading takes one word per cycle; after the final word two passes over the
// vector ram run (one compare per cycle against a held vector), then n result
// words follow, each through S_ORD and S_OLOAD, which waits while the output is stalled
// throughput is one list at a time; rst (synchronous) clears counts and the fsm
// depends on vdib_pkg and vdib_ram
module vector_dedup_index_builder #(
  parameter int MAX_ITEMS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  vdib_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output vdib_pkg::result_t result
);
  import vdib_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  state_t state, state_next;

  // run control
  logic [CW-1:0] load_count;
  logic          overflow_seen;
  logic [CW-1:0] n_items;
  logic          pass;          // 0: find first of each group, 1: rank
  logic [CW-1:0] i_idx;
  logic [CW-1:0] iss;           // scan read issue pointer
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [95:0]   vec_i;
  logic [95:0]   key_i;
  logic          dup;
  logic [CW-1:0] lt_cnt;
  logic [CW-1:0] d_cnt;
  logic [MAX_ITEMS-1:0] first_flag;
  logic [CW-1:0] m_idx;

  // ram ports
  logic          vec_we;
  logic [AW-1:0] vec_raddr;
  logic [95:0]   vec_rdata;
  logic          rank_we;
  logic [AW-1:0] rank_rdata;
  logic          uniq_we;
  logic [95:0]   uniq_rdata;

  logic          accept_in;
  logic          out_load;
  logic [95:0]   key_j;
  logic          last_i;
  logic          last_m;

  assign accept_in = item_valid && item_ready;
  assign vec_we    = accept_in && (load_count < CW'(MAX_ITEMS));
  assign key_j     = vec_key(vec_rdata);
  assign last_i    = (i_idx + CW'(1)) == n_items;
  assign last_m    = (m_idx + CW'(1)) == n_items;
  assign rank_we   = (state == S_COMMIT) && pass;
  assign uniq_we   = rank_we && first_flag[i_idx[AW-1:0]];
  assign out_load  = (state == S_OLOAD) && (!result_valid || result_ready);

  always_comb begin
    vec_raddr = iss[AW-1:0];
    if (state == S_FETCH) begin
      vec_raddr = i_idx[AW-1:0];
    end
  end

  vdib_ram #(.WIDTH(96), .DEPTH(MAX_ITEMS)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (load_count[AW-1:0]),
    .wdata ({item.comp_x, item.comp_y, item.comp_z}),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  vdib_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (i_idx[AW-1:0]),
    .wdata (lt_cnt[AW-1:0]),
    .raddr (m_idx[AW-1:0]),
    .rdata (rank_rdata)
  );

  vdib_ram #(.WIDTH(96), .DEPTH(MAX_ITEMS)) u_uniq_ram (
    .clk   (clk),
    .we    (uniq_we),
    .waddr (lt_cnt[AW-1:0]),
    .wdata (vec_i),
    .raddr (m_idx[AW-1:0]),
    .rdata (uniq_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    unique case (state)
      S_LOAD: begin
        item_ready = 1'b1;
        if (accept_in && item.final_item) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH:  state_next = S_HOLD;
      S_HOLD:   state_next = S_SCAN;
      S_SCAN: begin
        // last compare of this row arrives
        if (rd_vld && (CW'(rd_idx) == CW'(n_items - CW'(1)))) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!last_i) begin
          state_next = S_FETCH;
        end else if (!pass) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_ORD;
        end
      end
      S_ORD:    state_next = S_OLOAD;
      S_OLOAD: begin
        if (out_load) begin
          state_next = last_m ? S_LOAD : S_ORD;
        end
      end
      default:  state_next = S_LOAD;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      rd_vld        <= 1'b0;
    end else begin
      if (accept_in) begin
        if (vec_we) begin
          load_count <= load_count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (out_load) begin
        result_valid <= 1'b1;
        if (last_m) begin
          load_count    <= '0;
          overflow_seen <= 1'b0;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      rd_vld <= (state == S_SCAN) && (iss < n_items);
    end
  end

  // pass datapath
  always_ff @(posedge clk) begin
    rd_idx <= iss[AW-1:0];
    unique case (state)
      S_LOAD: begin
        n_items <= vec_we ? load_count + CW'(1) : load_count;
        pass    <= 1'b0;
        i_idx   <= '0;
        d_cnt   <= '0;
        m_idx   <= '0;
      end
      S_HOLD: begin
        vec_i  <= vec_rdata;
        key_i  <= key_j;
        iss    <= '0;
        dup    <= 1'b0;
        lt_cnt <= '0;
      end
      S_SCAN: begin
        if (iss < n_items) begin
          iss <= iss + CW'(1);
        end
        if (rd_vld) begin
          if (!pass && (CW'(rd_idx) < i_idx) && (key_j == key_i)) begin
            dup <= 1'b1;
          end
          if (pass && first_flag[rd_idx] && (key_j < key_i)) begin
            lt_cnt <= lt_cnt + CW'(1);
          end
        end
      end
      S_COMMIT: begin
        if (!pass) begin
          first_flag[i_idx[AW-1:0]] <= !dup;
          if (!dup) begin
            d_cnt <= d_cnt + CW'(1);
          end
        end
        if (last_i) begin
          i_idx <= '0;
          pass  <= 1'b1;
        end else begin
          i_idx <= i_idx + CW'(1);
        end
      end
      S_OLOAD: begin
        if (out_load) begin
          m_idx <= m_idx + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      result.rank_index <= 6'(rank_rdata);
      result.uniq_valid <= m_idx < d_cnt;
      result.uniq_x     <= (m_idx < d_cnt) ? uniq_rdata[95:64] : 32'h0;
      result.uniq_y     <= (m_idx < d_cnt) ? uniq_rdata[63:32] : 32'h0;
      result.uniq_z     <= (m_idx < d_cnt) ? uniq_rdata[31:0]  : 32'h0;
      result.uniq_total <= 7'(d_cnt);
      result.overflow   <= overflow_seen;
      result.end_of_run <= last_m;
    end
  end

endmodule

@@ rtl/core/vdib_ram.sv @@
// simple dual-port ram, one write and one registered read port
// depends on nothing
module vdib_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/vdib_checker.sv @@
// port-level assertions for the vector dedup index builder, bound to the top
// depends on vdib_pkg and vector_dedup_index_builder
module vdib_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input vdib_pkg::result_t result
);
  import vdib_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_rank: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (7'(result.rank_index) < result.uniq_total))
    else $error("rank beyond unique count");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.uniq_valid |->
      result.uniq_x == 32'h0 && result.uniq_y == 32'h0 && result.uniq_z == 32'h0)
    else $error("unique vector not cleared");

endmodule

bind vector_dedup_index_builder vdib_checker u_vdib_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ dv/tb_top.sv @@
// testbench for the vector dedup index builder: lists of float vectors in,
// ranked unique-table results out, checked against a behavioural predictor
// depends on vdib_pkg and vector_dedup_index_builder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vdib_pkg::*;

  localparam int CAP = 64;
  localparam int LIMIT_CYCLES = 3_000_000;

  // scoreboard: keeps the list being loaded and the queue of expected words
  class dedup_scoreboard;
    logic [95:0] list_vecs[$];
    bit          list_over;
    result_t     pending_words[$];
    int          errors;

    // numeric order of one float pattern, signed zeros folded together
    function automatic logic [31:0] num_key(logic [31:0] b);
      if (b == 32'h8000_0000) b = 0;
      return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

    function automatic int vcmp(logic [95:0] a, logic [95:0] b);
      logic [31:0] ka, kb;
      for (int i = 2; i >= 0; i--) begin
        ka = num_key(a[i*32 +: 32]);
        kb = num_key(b[i*32 +: 32]);
        if (ka < kb) return -1;
        if (ka > kb) return 1;
      end
      return 0;
    endfunction

    function void note_item(item_t it);
      logic [95:0] srt[$];
      logic [95:0] uq[$];
      logic [95:0] t;
      result_t r;
      int j, rank;
      if (list_vecs.size() < CAP) list_vecs.push_back({it.comp_x, it.comp_y, it.comp_z});
      else list_over = 1;
      if (!it.final_item) return;
      // stable insertion sort
      foreach (list_vecs[i]) begin
        t = list_vecs[i];
        j = srt.size();
        while (j > 0 && vcmp(srt[j-1], t) > 0) j--;
        srt.insert(j, t);
      end
      foreach (srt[i])
        if (uq.size() == 0 || vcmp(uq[uq.size()-1], srt[i]) != 0) uq.push_back(srt[i]);
      foreach (list_vecs[m]) begin
        rank = 0;
        foreach (uq[k]) begin
          if (vcmp(uq[k], list_vecs[m]) >= 0) break;
          rank++;
        end
        if (rank >= uq.size()) rank = 0;
        r = '0;
        r.rank_index = rank[5:0];
        if (m < uq.size()) begin
          r.uniq_valid = 1;
          {r.uniq_x, r.uniq_y, r.uniq_z} = uq[m];
        end
        r.uniq_total = 7'(uq.size());
        r.overflow   = list_over;
        r.end_of_run = (m == list_vecs.size() - 1);
        pending_words.push_back(r);
      end
      list_vecs.delete();
      list_over = 0;
    endfunction

    function void check_word(result_t got);
      result_t exp;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.rank_index !== exp.rank_index)
        $display("%0t: rank_index exp %0d got %0d", $time, exp.rank_index, got.rank_index);
      if (got.uniq_valid !== exp.uniq_valid)
        $display("%0t: uniq_valid exp %0d got %0d", $time, exp.uniq_valid, got.uniq_valid);
      if (got.uniq_x !== exp.uniq_x)
        $display("%0t: uniq_x exp %h got %h", $time, exp.uniq_x, got.uniq_x);
      if (got.uniq_y !== exp.uniq_y)
        $display("%0t: uniq_y exp %h got %h", $time, exp.uniq_y, got.uniq_y);
      if (got.uniq_z !== exp.uniq_z)
        $display("%0t: uniq_z exp %h got %h", $time, exp.uniq_z, got.uniq_z);
      if (got.uniq_total !== exp.uniq_total)
        $display("%0t: uniq_total exp %0d got %0d", $time, exp.uniq_total, got.uniq_total);
      if (got.overflow !== exp.overflow)
        $display("%0t: overflow exp %0d got %0d", $time, exp.overflow, got.overflow);
      if (got.end_of_run !== exp.end_of_run)
        $display("%0t: end_of_run exp %0d got %0d", $time, exp.end_of_run, got.end_of_run);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic    clk = 0;
  logic    rst = 1;
  logic    item_valid = 0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 0;
  result_t result;

  dedup_scoreboard sb = new();
  int send_idle_pct = 0;   // sender gap chance, percent
  int recv_stall_pct = 0;  // receiver stall chance, percent
  int hold_off = 0;        // long receiver hold-off, in cycles
  int cycle_count = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  vector_dedup_index_builder #(.MAX_ITEMS(CAP)) dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready, .result
  );

  // sample handshakes at the edge, before any driver moves
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note_item(item);
    if (!rst && result_valid && result_ready) sb.check_word(result);
  end

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result_ready <= 0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one word and wait for it to be taken; gaps come before the word
  task automatic send_word(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item <= '{comp_x: x, comp_y: y, comp_z: z, final_item: fin};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic go_quiet();
    item_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // float-ish component: specials, sign flips of a small pool, or raw bits
  function automatic logic [31:0] rand_comp(int pool);
    logic [31:0] specials[8] = '{32'h0, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                                 32'h3f80_0000, 32'hbf80_0000, 32'h0000_0001, 32'h7f7f_ffff};
    case ($urandom_range(3))
      0: return specials[$urandom_range(7)];
      1: return $urandom;
      default: return {1'($urandom), 31'($urandom_range(pool))};
    endcase
  endfunction

  // a list of n vectors; small pools give plenty of duplicates
  // close marks the last vector as final
  task automatic send_list(int n, int pool, bit close = 1);
    logic [31:0] x, y, z;
    logic [95:0] seen[$];
    for (int i = 0; i < n; i++) begin
      if (seen.size() > 0 && $urandom_range(2) == 0) begin
        {x, y, z} = seen[$urandom_range(seen.size() - 1)];
        if ($urandom_range(3) == 0 && x[30:0] == 0) x[31] = ~x[31];  // other zero
      end else begin
        x = rand_comp(pool);
        y = rand_comp(pool);
        z = rand_comp(pool);
      end
      seen.push_back({x, y, z});
      send_word(x, y, z, close && (i == n - 1));
    end
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: single vector, signed zeros, extremes, all-equal, ordering
    send_word(32'h0, 32'h0, 32'h0, 1);
    send_word(32'h8000_0000, 32'h0, 32'h8000_0000, 0);
    send_word(32'h0, 32'h8000_0000, 32'h0, 0);
    send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_word(32'h7f80_0000, 32'hff80_0000, 32'h3f80_0000, 0);
    send_word(32'hff80_0000, 32'h7f80_0000, 32'hbf80_0000, 0);
    send_word(32'h3f80_0000, 32'h3f80_0000, 32'h3f80_0000, 0);
    send_word(32'h3f80_0000, 32'h3f80_0000, 32'h4000_0000, 0);
    send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
    for (int i = 0; i < 3; i++) send_word(32'h4040_0000, 32'h1, 32'h2, i == 2);
    go_quiet();
    drain();

    // overflow: a full list plus extras, then a dropped final word
    send_list(CAP, 7, 0);
    for (int i = 0; i < 3; i++) send_word($urandom, $urandom, $urandom, i == 2);

    // random phases over the idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 24) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 24) : 0;
      if (ph == 2) hold_off = 3000;  // sender keeps offering while the output is held
      for (int k = 0; k < 8; k++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(40, CAP) : $urandom_range(1, 12);
        send_list(n, $urandom_range(1, 4) * 3);
      end
      go_quiet();
      drain();  // sender pauses until all results are in
    end

    go_quiet();
    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
